>>> hdl/ftpp_pkg.sv
// ----------------------------------------------------------------------------
// ftpp_pkg: shared types and constants for the PORT argument parser
// Field count, phase and verdict codes, and the result beat layout.
// ----------------------------------------------------------------------------
package ftpp_pkg;

   localparam int NUM_FIELDS      = 6;
   localparam int MAX_FIELD_VALUE = 255;
   localparam int ACCUM_SAT       = 256;
   localparam int ACCUM_W         = 9;
   localparam int COUNT_W         = 3;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // position inside the current field
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_BLANK  = 3'd1,
      PH_LEAD   = 3'd2,
      PH_SIGN   = 3'd3,
      PH_DIGITS = 3'd4,
      PH_TRAIL  = 3'd5
   } phase_type;

   // verdict doubles as the status code once decided
   typedef enum logic [1:0] {
      V_OK     = 2'd0,
      V_FORMAT = 2'd1,
      V_COUNT  = 2'd2,
      V_OPEN   = 2'd3
   } verdict_type;

   typedef struct packed {
      phase_type            phase;
      logic [COUNT_W-1:0]   count;
      logic [ACCUM_W-1:0]   accum;
      logic                 minus;
      verdict_type          verdict;
   } arg_state_type;

   localparam arg_state_type ARG_CLEAR = '{
      phase:   PH_IDLE,
      count:   '0,
      accum:   '0,
      minus:   1'b0,
      verdict: V_OPEN
   };

   // one result beat
   typedef struct packed {
      logic [1:0]                  status;
      logic [NUM_FIELDS-1:0][7:0]  fields;
   } result_type;

endpackage

>>> hdl/ftp_port_argument_parser.sv
// ----------------------------------------------------------------------------
// ftp_port_argument_parser: FTP PORT argument parser, one byte per beat
// Splits h1,h2,h3,h4,p1,p2 into address and port bytes with error status.
// ----------------------------------------------------------------------------
// The result beat is registered in the output register or the skid entry before rsp_valid shows it.
// Throughput: one byte per cycle while req_ready is high; the parser state updates in a single pass.
// A two-entry result buffer keeps input flowing while a result waits.
// Synchronous reset clears the parser state and empties the result buffer.
module ftp_port_argument_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_addr_byte0,
   output logic [7:0]  rsp_addr_byte1,
   output logic [7:0]  rsp_addr_byte2,
   output logic [7:0]  rsp_addr_byte3,
   output logic [7:0]  rsp_port_high,
   output logic [7:0]  rsp_port_low,
   output logic [15:0] rsp_port_number
);
   import ftpp_pkg::*;

   logic       accept;
   logic       res_valid;
   result_type res;

   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       pop;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   ftpp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_byte (req_char_byte),
      .last      (req_last),
      .res_valid (res_valid),
      .res       (res)
   );

   // result buffer: output register plus skid entry
   always_comb begin
      pop           = out_valid_ff && rsp_ready;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_valid;
         end
      end else if (!out_valid_ff) begin
         out_in       = res;
         out_valid_in = res_valid;
      end else if (res_valid) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_addr_byte0  = out_ff.fields[0];
   assign rsp_addr_byte1  = out_ff.fields[1];
   assign rsp_addr_byte2  = out_ff.fields[2];
   assign rsp_addr_byte3  = out_ff.fields[3];
   assign rsp_port_high   = out_ff.fields[4];
   assign rsp_port_low    = out_ff.fields[5];
   assign rsp_port_number = {out_ff.fields[4], out_ff.fields[5]};

endmodule

>>> hdl/ftpp_core.sv
// ----------------------------------------------------------------------------
// ftpp_core: per-byte argument parser
// Holds the field state, steps it by one accepted byte and forms the
// result beat combinationally when the argument ends.
// ----------------------------------------------------------------------------
module ftpp_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_byte,
   input  logic                last,
   output logic                res_valid,
   output ftpp_pkg::result_type res
);
   import ftpp_pkg::*;

   typedef struct packed {
      arg_state_type       st;
      logic                wr_en;
      logic [COUNT_W-1:0]  wr_idx;
      logic [7:0]          wr_val;
   } close_type;

   function automatic logic is_sp_tab(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_other_ws(input logic [7:0] c);
      return (c >= CH_LF) && (c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // end of a field: check it and store its value
   function automatic close_type close_fn(input arg_state_type s);
      close_type r;
      r        = '0;
      r.st     = s;
      r.wr_idx = s.count;
      r.wr_val = s.accum[7:0];
      unique case (s.phase)
         PH_IDLE: begin
         end
         PH_BLANK: begin
            r.st.verdict = V_COUNT;
         end
         PH_DIGITS, PH_TRAIL: begin
            if ((s.minus && (s.accum != '0)) ||
                (s.accum > ACCUM_W'(MAX_FIELD_VALUE))) begin
               r.st.verdict = V_FORMAT;
            end else begin
               r.wr_en    = (s.count < COUNT_W'(NUM_FIELDS));
               r.st.count = s.count + 1'b1;
               if (r.st.count >= COUNT_W'(NUM_FIELDS)) begin
                  r.st.verdict = V_OK;
               end
               r.st.phase = PH_IDLE;
               r.st.accum = '0;
               r.st.minus = 1'b0;
            end
         end
         default: begin
            r.st.verdict = V_FORMAT;
         end
      endcase
      return r;
   endfunction

   // one non-comma character inside a field
   function automatic arg_state_type take_fn(input arg_state_type s, input logic [7:0] c);
      arg_state_type r;
      logic [11:0]   wide;
      logic [11:0]   prod;
      logic [ACCUM_W-1:0] dig;
      r    = s;
      wide = {3'b000, s.accum};
      dig  = ACCUM_W'(c - CH_ZERO);
      prod = (wide << 3) + (wide << 1) + {3'b000, dig};
      unique case (s.phase)
         PH_IDLE, PH_BLANK, PH_LEAD: begin
            if ((s.phase != PH_LEAD) && is_sp_tab(c)) begin
               r.phase = PH_BLANK;
            end else if (is_sp_tab(c) || is_other_ws(c)) begin
               r.phase = PH_LEAD;
            end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
               r.minus = (c == CH_MINUS);
               r.phase = PH_SIGN;
            end else if (is_digit(c)) begin
               r.accum = dig;
               r.phase = PH_DIGITS;
            end else begin
               r.verdict = V_FORMAT;
            end
         end
         PH_SIGN: begin
            if (is_digit(c)) begin
               r.accum = dig;
               r.phase = PH_DIGITS;
            end else begin
               r.verdict = V_FORMAT;
            end
         end
         PH_DIGITS: begin
            if (is_digit(c)) begin
               // saturate so any overlong number stays above the limit
               if (prod > 12'(ACCUM_SAT)) begin
                  r.accum = ACCUM_W'(ACCUM_SAT);
               end else begin
                  r.accum = prod[ACCUM_W-1:0];
               end
            end else if (is_sp_tab(c)) begin
               r.phase = PH_TRAIL;
            end else begin
               r.verdict = V_FORMAT;
            end
         end
         default: begin
            if (!is_sp_tab(c)) begin
               r.verdict = V_FORMAT;
            end
         end
      endcase
      return r;
   endfunction

   arg_state_type             arg_ff, arg_in;
   logic                      string_ended_ff, string_ended_in;
   logic [7:0]                field_values_ff [NUM_FIELDS];

   arg_state_type             arg_a, arg_b;
   close_type                 cl_take, cl_fin;
   logic                      fin, restart;
   logic                      wr_en;
   logic [COUNT_W-1:0]        wr_idx;
   logic [7:0]                wr_val;
   logic [1:0]                status;
   logic [NUM_FIELDS-1:0][7:0] vals;

   // step the parser by one byte
   always_comb begin
      arg_a           = arg_ff;
      string_ended_in = string_ended_ff;
      fin             = 1'b0;
      restart         = 1'b0;
      cl_take         = close_fn(arg_ff);
      wr_en           = 1'b0;
      wr_idx          = cl_take.wr_idx;
      wr_val          = cl_take.wr_val;
      if (accept) begin
         if (string_ended_ff) begin
            // skip to the byte marked last
            if (last) begin
               string_ended_in = 1'b0;
               restart         = 1'b1;
            end
         end else if (char_byte == CH_NUL) begin
            fin             = 1'b1;
            string_ended_in = !last;
         end else begin
            if (arg_ff.verdict == V_OPEN) begin
               if (char_byte == CH_COMMA) begin
                  arg_a = cl_take.st;
                  wr_en = cl_take.wr_en;
               end else begin
                  arg_a = take_fn(arg_ff, char_byte);
               end
            end
            fin = last;
         end
      end

      // end of argument: close the open field, then decide
      arg_b  = arg_a;
      cl_fin = close_fn(arg_a);
      if (arg_a.verdict == V_OPEN) begin
         arg_b = cl_fin.st;
         if (fin && cl_fin.wr_en) begin
            wr_en  = 1'b1;
            wr_idx = cl_fin.wr_idx;
            wr_val = cl_fin.wr_val;
         end
      end
      status = (arg_b.verdict == V_OPEN) ? V_COUNT : arg_b.verdict;

      arg_in = (fin || restart) ? ARG_CLEAR : arg_a;
   end

   // field values with this beat's write folded in
   always_comb begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
         if (wr_en && (wr_idx == COUNT_W'(i))) begin
            vals[i] = wr_val;
         end else begin
            vals[i] = field_values_ff[i];
         end
      end
   end

   assign res_valid  = fin;
   assign res.status = status;
   assign res.fields = (status == V_OK) ? vals : '0;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         arg_ff          <= ARG_CLEAR;
         string_ended_ff <= 1'b0;
      end else begin
         arg_ff          <= arg_in;
         string_ended_ff <= string_ended_in;
      end
   end

   // field value store, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         field_values_ff[wr_idx] <= wr_val;
      end
   end

endmodule
